// ----- rtl/firmware_update_receiver_macros.svh -----
// Assertion macros for the firmware update receiver.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef FIRMWARE_UPDATE_RECEIVER_MACROS_SVH
`define FIRMWARE_UPDATE_RECEIVER_MACROS_SVH

// The property must hold in the same cycle.
`define FWUR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FWUR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fwur_pkg.sv -----
// Package of the firmware update receiver: payload structs, codes and the CRC function.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fwur_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 1024;
    localparam int Q_DEPTH             = 2;
    localparam int Q_PTR_W             = $clog2(Q_DEPTH);
    localparam int Q_CNT_W             = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_TOP  = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_DATA  = 2'd1,
        OP_END   = 2'd2,
        OP_OTHER = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IGNORED   = 4'd0,
        ST_BEGIN_OK  = 4'd1,
        ST_WRITTEN   = 4'd2,
        ST_LEN_ERR   = 4'd3,
        ST_TOO_LARGE = 4'd4,
        ST_SIZE_BAD  = 4'd5,
        ST_CRC_BAD   = 4'd6,
        ST_COMPLETE  = 4'd7,
        ST_DISABLED  = 4'd8,
        ST_BEGIN_REJ = 4'd9
    } t_status;

    typedef enum logic {
        CFG_APP_BASE   = 1'b0,
        CFG_PART_BYTES = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [10:0] frame_length;
        logic [63:0] chunk_word;
        logic        swap_order;
        logic        last_chunk;
    } t_in_item;

    typedef struct packed {
        logic        flash_write;
        logic [31:0] flash_address;
        logic [63:0] flash_word;
        logic [3:0]  status;
    } t_out_item;

    // A word after classification by the front part.
    typedef struct packed {
        logic        first;      // first chunk of a frame
        t_op         op;
        logic        len_bad;    // data length not a multiple of 8 or too long
        logic        len_is4;
        logic        len_zero;
        logic [31:0] size;       // begin size after byte order fix
        logic        size_ok;
        logic [63:0] word;
        logic        last;
    } t_cmd;

    // MSB-first CRC step over one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = ((c & CRC_TOP) != 32'h0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Eight bytes, first byte in bits 7 to 0.
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [63:0] w);
        logic [31:0] c;
        c = crc;
        for (int b = 0; b < 8; b++) begin
            c = crc_byte(c, w[8*b +: 8]);
        end
        return c;
    endfunction

endpackage

// ----- rtl/fwur_front.sv -----
// Front part: accepts input words, tracks frame boundaries and classifies each word.
// Depends on fwur_pkg.
`timescale 1ns / 1ps

module fwur_front import fwur_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic r_inside;
    logic n_inside;
    logic [31:0] w_size_raw;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign w_size_raw = i_in_item.chunk_word[31:0];

    always_comb begin
        o_cmd.first    = !r_inside;
        o_cmd.op       = t_op'(i_in_item.opcode);
        o_cmd.len_bad  = (i_in_item.frame_length[2:0] != 3'd0)
                      || (32'(i_in_item.frame_length) > 32'(MAX_FRAME_BYTES));
        o_cmd.len_is4  = (i_in_item.frame_length == 11'd4);
        o_cmd.len_zero = (i_in_item.frame_length == 11'd0);
        o_cmd.size     = i_in_item.swap_order
                       ? {w_size_raw[7:0], w_size_raw[15:8], w_size_raw[23:16], w_size_raw[31:24]}
                       : w_size_raw;
        o_cmd.size_ok  = (o_cmd.size[2:0] == 3'd0);
        o_cmd.word     = i_in_item.chunk_word;
        o_cmd.last     = i_in_item.last_chunk;
    end

    // A frame is open from a word without the last mark up to the word that has it.
    always_comb begin
        n_inside = r_inside;
        if (o_push) begin
            n_inside = !i_in_item.last_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
        end else begin
            r_inside <= n_inside;
        end
    end

endmodule

// ----- rtl/fwur_queue.sv -----
// Two-entry queue of classified words between the front and the back part.
// Depends on fwur_pkg.
`timescale 1ns / 1ps

module fwur_queue import fwur_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_cmd               i_cmd,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output t_cmd               o_cmd,
    output logic [Q_CNT_W-1:0] o_count
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/fwur_back.sv -----
// Back part: runs the update state, the CRC and the byte count, and holds the output word.
// Depends on fwur_pkg.
`timescale 1ns / 1ps

module fwur_back import fwur_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    input  t_cfg_reg  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic      i_q_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic [31:0] r_app_base;
    logic [31:0] r_part_bytes;
    logic        r_enabled;
    logic        r_phase;
    logic [31:0] r_expected;
    logic [31:0] r_bytes;
    logic [31:0] r_crc;
    logic        r_dropping;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        n_enabled;
    logic        n_phase;
    logic [31:0] n_expected;
    logic [31:0] n_bytes;
    logic [31:0] n_crc;
    logic        n_dropping;
    logic        n_out_valid;
    t_out_item   n_out;
    t_status     w_status;
    logic        w_data_ok;
    logic        w_write;
    logic [31:0] w_crc_next;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_crc_next  = crc_word(r_crc, i_cmd.word);

    always_comb begin
        n_enabled  = r_enabled;
        n_phase    = r_phase;
        n_expected = r_expected;
        n_bytes    = r_bytes;
        n_crc      = r_crc;
        n_dropping = r_dropping;
        w_status   = ST_IGNORED;
        w_data_ok  = 1'b0;
        w_write    = 1'b0;

        if (!i_cmd.first) begin
            if (!r_dropping) begin
                w_status = ST_WRITTEN;
                w_write  = !i_cmd.len_zero;
            end
        end else if (!r_enabled) begin
            w_status = ST_DISABLED;
        end else if (!r_phase) begin
            if (i_cmd.op == OP_BEGIN) begin
                if (!i_cmd.len_is4 || !i_cmd.size_ok) begin
                    w_status = ST_BEGIN_REJ;
                end else begin
                    n_expected = i_cmd.size;
                    n_crc      = CRC_INIT;
                    n_bytes    = '0;
                    n_phase    = 1'b1;
                    w_status   = ST_BEGIN_OK;
                end
            end
        end else if (i_cmd.op == OP_DATA) begin
            // The length check takes precedence over the partition limit.
            if (i_cmd.len_bad) begin
                n_phase  = 1'b0;
                w_status = ST_LEN_ERR;
            end else if (r_bytes >= r_part_bytes) begin
                n_phase  = 1'b0;
                w_status = ST_TOO_LARGE;
            end else begin
                w_data_ok = 1'b1;
                w_status  = ST_WRITTEN;
                w_write   = !i_cmd.len_zero;
            end
        end else if (i_cmd.op == OP_END) begin
            n_phase = 1'b0;
            if (r_bytes != r_expected) begin
                w_status = ST_SIZE_BAD;
            end else if (!i_cmd.len_is4 || r_crc != i_cmd.word[31:0]) begin
                w_status = ST_CRC_BAD;
            end else begin
                n_enabled = 1'b0;
                w_status  = ST_COMPLETE;
            end
        end

        if (w_write) begin
            n_crc   = w_crc_next;
            n_bytes = r_bytes + 32'd8;
        end

        if (i_cmd.last) begin
            n_dropping = 1'b0;
        end else if (i_cmd.first) begin
            n_dropping = !w_data_ok;
        end

        n_out.flash_write   = w_write;
        n_out.flash_address = w_write ? (r_app_base + r_bytes) : 32'h0;
        n_out.flash_word    = w_write ? i_cmd.word : 64'h0;
        n_out.status        = w_status;

        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_base   <= '0;
            r_part_bytes <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_APP_BASE:   r_app_base   <= i_cfg_data;
                CFG_PART_BYTES: r_part_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_phase     <= 1'b0;
            r_expected  <= '0;
            r_bytes     <= '0;
            r_crc       <= CRC_INIT;
            r_dropping  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_enabled  <= n_enabled;
                r_phase    <= n_phase;
                r_expected <= n_expected;
                r_bytes    <= n_bytes;
                r_crc      <= n_crc;
                r_dropping <= n_dropping;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/firmware_update_receiver.sv -----
// Firmware update receiver: one result word for every accepted input word.
// Each accepted input word is written into the queue, and the back part registers its result
// in the output register when it takes the word from the queue.
// Throughput is one word per cycle while the output is not stalled, set by the combinational 64-bit CRC network.
// A two-entry queue parts front and back; downstream stall fills it before input stalls.
// Synchronous active-low reset: idle, update enabled, CRC all ones, registers zero.
`timescale 1ns / 1ps
`include "firmware_update_receiver_macros.svh"

module firmware_update_receiver import fwur_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_reg    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic               w_push;
    logic               w_pop;
    logic               w_q_full;
    logic               w_q_valid;
    logic [Q_CNT_W-1:0] w_q_count;
    t_cmd               w_cmd_in;
    t_cmd               w_cmd_out;

    assign o_cfg_ready = 1'b1;

    fwur_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    fwur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out),
        .o_count (w_q_count)
    );

    fwur_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    `FWUR_ASSERT(a_write_status, !(o_out_valid && o_out_item.flash_write) || (o_out_item.status == ST_WRITTEN), "flash write without written status")
    `FWUR_ASSERT(a_status_range, !o_out_valid || (o_out_item.status <= ST_BEGIN_REJ), "status code out of range")
    `FWUR_ASSERT_NEXT(a_word_kept, i_in_valid && !o_in_stall, (w_q_count != '0) || o_out_valid, "accepted word was lost")

endmodule

// ----- tb/sv/firmware_update_receiver_tb.sv -----
// Self-checking testbench for firmware_update_receiver: a directed table of update frames,
// then random update sessions under several register settings, with random idling.
// Depends on fwur_pkg and the firmware_update_receiver RTL only.
`timescale 1ns / 1ps

module firmware_update_receiver_tb;
    import fwur_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int MAX_LEN      = 1024;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 700;
    localparam int N_PHASES     = 6;

    typedef struct {
        t_in_item  w;
        bit        typed;
        t_out_item res;
    } t_directed_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_reg    i_cfg_index = CFG_APP_BASE;
    logic [31:0] i_cfg_data  = '0;

    // Receiver model state, starting at its reset values.
    logic [31:0] app_base    = '0;
    logic [31:0] part_limit  = '0;
    logic        upd_enabled = 1'b1;
    logic        armed       = 1'b0;
    logic        in_frame    = 1'b0;
    logic        skip_frame  = 1'b0;
    logic [31:0] want_bytes  = '0;
    logic [31:0] got_bytes   = '0;
    logic [31:0] image_crc   = CRC_INIT;

    t_out_item   expected_words[$];
    int unsigned errors  = 0;
    int unsigned cycles  = 0;
    int unsigned counted = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    firmware_update_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Bit-serial MSB-first CRC; bytes go in from bits 7..0 upward.
    function automatic logic [31:0] crc_after_word(logic [31:0] crc, logic [63:0] w);
        logic fb;
        for (int i = 0; i < 64; i++) begin
            fb  = crc[31] ^ w[8 * (i / 8) + 7 - (i % 8)];
            crc = {crc[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
        end
        return crc;
    endfunction

    function automatic logic [31:0] byte_swap(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic t_in_item word_of(t_op op, int unsigned len, logic [63:0] data,
                                         bit swap, bit last);
        t_in_item w;
        w.opcode       = op;
        w.frame_length = 11'(len);
        w.chunk_word   = data;
        w.swap_order   = swap;
        w.last_chunk   = last;
        return w;
    endfunction

    function automatic t_out_item result_of(bit wr, logic [31:0] addr, logic [63:0] data,
                                            t_status st);
        t_out_item r;
        r.flash_write   = wr;
        r.flash_address = addr;
        r.flash_word    = data;
        r.status        = st;
        return r;
    endfunction

    function automatic t_out_item status_only(t_status st);
        return result_of(1'b0, '0, '0, st);
    endfunction

    function automatic t_out_item program_word(t_in_item w);
        t_out_item r;
        r = status_only(ST_WRITTEN);
        if (w.frame_length != '0) begin
            r.flash_write   = 1'b1;
            r.flash_address = app_base + got_bytes;
            r.flash_word    = w.chunk_word;
            image_crc       = crc_after_word(image_crc, w.chunk_word);
            got_bytes       = got_bytes + 32'd8;
        end
        return r;
    endfunction

    // Advances the model by one input word and returns the result word it causes.
    function automatic t_out_item receiver_step(t_in_item w);
        t_out_item   r;
        logic [31:0] size;
        bit          opened;
        r      = status_only(ST_IGNORED);
        opened = 1'b0;
        if (in_frame) begin
            if (!skip_frame) r = program_word(w);
        end else if (!upd_enabled) begin
            r.status = ST_DISABLED;
        end else if (!armed) begin
            if (w.opcode == OP_BEGIN) begin
                size = w.swap_order ? byte_swap(w.chunk_word[31:0]) : w.chunk_word[31:0];
                if (w.frame_length != 11'd4 || size[2:0] != 3'd0) begin
                    r.status = ST_BEGIN_REJ;
                end else begin
                    want_bytes = size;
                    image_crc  = CRC_INIT;
                    got_bytes  = '0;
                    armed      = 1'b1;
                    r.status   = ST_BEGIN_OK;
                end
            end
        end else if (w.opcode == OP_DATA) begin
            if (w.frame_length[2:0] != 3'd0 || w.frame_length > MAX_LEN) begin
                armed    = 1'b0;
                r.status = ST_LEN_ERR;
            end else if (got_bytes >= part_limit) begin
                armed    = 1'b0;
                r.status = ST_TOO_LARGE;
            end else begin
                opened = 1'b1;
                r      = program_word(w);
            end
        end else if (w.opcode == OP_END) begin
            armed = 1'b0;
            if (got_bytes != want_bytes) begin
                r.status = ST_SIZE_BAD;
            end else if (w.frame_length != 11'd4 || image_crc != w.chunk_word[31:0]) begin
                r.status = ST_CRC_BAD;
            end else begin
                upd_enabled = 1'b0;
                r.status    = ST_COMPLETE;
            end
        end
        // Only a data frame accepted on its first word keeps its later words.
        if (w.last_chunk) begin
            in_frame   = 1'b0;
            skip_frame = 1'b0;
        end else if (!in_frame) begin
            in_frame   = 1'b1;
            skip_frame = !opened;
        end
        return r;
    endfunction

    function automatic int unsigned idle_cycles(bit calm);
        if (calm || $urandom_range(0, 9) < 4) return 0;
        return $urandom_range(1, 18);
    endfunction

    task automatic send_word(t_in_item w, bit typed = 1'b0, t_out_item res = '0);
        int unsigned gap;
        t_out_item   predicted;
        gap = idle_cycles(tx_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predicted = receiver_step(w);
        expected_words.push_back(typed ? res : predicted);
        counted++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_APP_BASE:   app_base   = value;
            CFG_PART_BYTES: part_limit = value;
        endcase
    endtask

    task automatic set_config(logic [31:0] base, logic [31:0] part);
        write_reg(CFG_APP_BASE, base);
        write_reg(CFG_PART_BYTES, part);
        i_cfg_valid <= 1'b0;
    endtask

    // One update: begin, a few data frames, end. Unless the image is to be finished,
    // the end word carries a corrupted CRC so the block stays enabled.
    task automatic update_session(bit finish_image);
        int unsigned frame_words[$];
        int unsigned planned;
        int unsigned n_words;
        int unsigned len;
        logic [31:0] size;
        logic [31:0] crc_low;
        bit          swap;
        tx_calm = ($urandom_range(0, 4) == 0);
        planned = 0;
        repeat ($urandom_range(finish_image ? 3 : 0, finish_image ? 8 : 4)) begin
            n_words = ($urandom_range(0, 19) == 0) ? MAX_LEN / 8 : $urandom_range(1, 4);
            frame_words.push_back(n_words);
            planned += 8 * n_words;
        end
        size = planned;
        if (!finish_image && $urandom_range(0, 5) == 0) size = $urandom & ~32'h7;
        swap = $urandom_range(0, 1);
        send_word(word_of(OP_BEGIN,
                          (finish_image || $urandom_range(0, 19) != 0) ? 4 : $urandom_range(0, 15),
                          {$urandom, swap ? byte_swap(size) : size}, swap,
                          finish_image || $urandom_range(0, 9) != 0));
        foreach (frame_words[f]) begin
            len     = 8 * frame_words[f];
            n_words = frame_words[f];
            if (!finish_image && $urandom_range(0, 9) == 0) len = $urandom_range(0, 2047);
            if (!finish_image && $urandom_range(0, 9) == 0)
                n_words = $urandom_range(1, n_words + 1);
            for (int i = 0; i < n_words; i++) begin
                send_word(word_of(i == 0 ? OP_DATA : t_op'($urandom_range(0, 3)),
                                  (!finish_image && i != 0 && $urandom_range(0, 7) == 0)
                                      ? 0 : len,
                                  {$urandom, $urandom}, $urandom_range(0, 1),
                                  i == n_words - 1));
            end
        end
        crc_low = image_crc;
        if (!finish_image) crc_low ^= 32'h1 << $urandom_range(0, 31);
        send_word(word_of(OP_END,
                          (finish_image || $urandom_range(0, 9) != 0) ? 4 : $urandom_range(0, 15),
                          {$urandom, crc_low}, $urandom_range(0, 1), 1'b1));
    endtask

    task automatic stray_words;
        int unsigned len;
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
                0:       len = 4;
                1:       len = 8 * $urandom_range(0, 3);
                default: len = $urandom_range(0, 2047);
            endcase
            send_word(word_of(t_op'($urandom_range(0, 3)), len, {$urandom, $urandom},
                              $urandom_range(0, 1), $urandom_range(0, 3) != 0));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: status %0d", o_out_item.status);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (o_out_item.flash_write !== want.flash_write) begin
                    $error("flash_write: expected %0d, actual %0d",
                           want.flash_write, o_out_item.flash_write);
                    errors++;
                end
                if (o_out_item.flash_address !== want.flash_address) begin
                    $error("flash_address: expected %h, actual %h",
                           want.flash_address, o_out_item.flash_address);
                    errors++;
                end
                if (o_out_item.flash_word !== want.flash_word) begin
                    $error("flash_word: expected %h, actual %h",
                           want.flash_word, o_out_item.flash_word);
                    errors++;
                end
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out_item.status);
                    errors++;
                end
            end
        end
    end

    initial begin : drive_out_stall
        int unsigned n;
        int unsigned served;
        served = 0;
        @(posedge i_clk);
        forever begin
            if (served % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            n = idle_cycles(rx_calm);
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            served++;
        end
    end

    initial begin : stimulus
        t_directed_row rows[$];
        int unsigned   target;

        // Base near the top of the address space so the third written word wraps to zero.
        rows.push_back('{word_of(OP_OTHER, 0, '0, 0, 1), 1'b1, status_only(ST_IGNORED)});
        rows.push_back('{word_of(OP_END, 4, '0, 0, 1), 1'b1, status_only(ST_IGNORED)});
        rows.push_back('{word_of(OP_BEGIN, 5, 64'd8, 0, 1), 1'b1, status_only(ST_BEGIN_REJ)});
        rows.push_back('{word_of(OP_BEGIN, 4, 64'd12, 0, 1), 1'b1, status_only(ST_BEGIN_REJ)});
        // Big-endian size of 16 in a begin frame that runs on for a second word.
        rows.push_back('{word_of(OP_BEGIN, 4, 64'h1000_0000, 1, 0), 1'b1,
                         status_only(ST_BEGIN_OK)});
        rows.push_back('{word_of(OP_DATA, 8, '1, 0, 1), 1'b1, status_only(ST_IGNORED)});
        rows.push_back('{word_of(OP_BEGIN, 4, 64'd8, 0, 1), 1'b1, status_only(ST_IGNORED)});
        rows.push_back('{word_of(OP_DATA, 8, '1, 0, 1), 1'b1,
                         result_of(1'b1, 32'hFFFF_FFF0, '1, ST_WRITTEN)});
        rows.push_back('{word_of(OP_DATA, 0, '1, 1, 1), 1'b1, status_only(ST_WRITTEN)});
        rows.push_back('{word_of(OP_DATA, 16, '0, 0, 0), 1'b0, '0});
        rows.push_back('{word_of(OP_OTHER, 16, 64'h0123_4567_89AB_CDEF, 0, 0), 1'b0, '0});
        rows.push_back('{word_of(OP_END, 0, {$urandom, $urandom}, 0, 1), 1'b0, '0});
        // Partition is full here, but the bad length is reported first.
        rows.push_back('{word_of(OP_DATA, 4, '0, 0, 1), 1'b1, status_only(ST_LEN_ERR)});
        rows.push_back('{word_of(OP_BEGIN, 4, 64'hFFFF_FFFF_0000_0010, 0, 1), 1'b1,
                         status_only(ST_BEGIN_OK)});
        rows.push_back('{word_of(OP_DATA, 1024, {$urandom, $urandom}, 0, 1), 1'b0, '0});
        rows.push_back('{word_of(OP_END, 3, '0, 0, 1), 1'b1, status_only(ST_SIZE_BAD)});
        rows.push_back('{word_of(OP_BEGIN, 4, '0, 1, 1), 1'b1, status_only(ST_BEGIN_OK)});
        rows.push_back('{word_of(OP_END, 4, 64'hFFFF_FFFE, 0, 1), 1'b1,
                         status_only(ST_CRC_BAD)});
        rows.push_back('{word_of(OP_BEGIN, 4, 64'hA5A5_A5A5_F8FF_FFFF, 1, 1), 1'b1,
                         status_only(ST_BEGIN_OK)});
        rows.push_back('{word_of(OP_DATA, 1032, '0, 0, 0), 1'b1, status_only(ST_LEN_ERR)});
        rows.push_back('{word_of(OP_DATA, 8, '0, 0, 1), 1'b1, status_only(ST_IGNORED)});
        rows.push_back('{word_of(OP_BEGIN, 4, 64'd16, 0, 1), 1'b1, status_only(ST_BEGIN_OK)});
        rows.push_back('{word_of(OP_DATA, 16, {$urandom, $urandom}, 0, 0), 1'b0, '0});
        rows.push_back('{word_of(OP_BEGIN, 16, {$urandom, $urandom}, 0, 1), 1'b0, '0});
        rows.push_back('{word_of(OP_DATA, 8, '0, 0, 1), 1'b1, status_only(ST_TOO_LARGE)});
        rows.push_back('{word_of(OP_DATA, 2047, '1, 1, 1), 1'b1, status_only(ST_IGNORED)});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(32'hFFFF_FFF0, 32'd16);
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                0:       set_config('0, '0);
                1:       set_config('1, '1);
                2:       set_config(32'hFFFF_FFF8, 32'd64);
                3:       set_config($urandom, 8 * $urandom_range(1, 75));
                4:       set_config($urandom, $urandom);
                default: set_config($urandom, '1);
            endcase
            target = counted + RANDOM_WORDS / N_PHASES;
            while (counted < target) begin
                if ($urandom_range(0, 9) < 7) update_session(1'b0);
                else stray_words();
            end
        end

        // Close any open frame and leave the transfer phase, then finish an image.
        drain();
        set_config($urandom & ~32'h7, '1);
        send_word(word_of(OP_OTHER, 0, '0, 0, 1));
        send_word(word_of(OP_END, 5, '0, 0, 1));
        update_session(1'b1);
        // The block is now disabled: only first words of frames report the disabled status.
        send_word(word_of(OP_BEGIN, 4, 64'd8, 0, 0));
        send_word(word_of(OP_DATA, 8, {$urandom, $urandom}, 0, 0));
        send_word(word_of(OP_DATA, 8, {$urandom, $urandom}, 0, 1));
        send_word(word_of(OP_DATA, 8, {$urandom, $urandom}, 1, 1));
        send_word(word_of(OP_END, 4, '0, 0, 1));

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fwur_pkg.sv
rtl/fwur_front.sv
rtl/fwur_queue.sv
rtl/fwur_back.sv
rtl/firmware_update_receiver.sv
tb/sv/firmware_update_receiver_tb.sv
